// ===== hdl/rtwj_pkg.sv =====
// ----------------------------------------------------------------------------
// rtwj_pkg
// Shared types and constants of the regulation time-window judge.
// ----------------------------------------------------------------------------
package rtwj_pkg;

    localparam int CODE_WIDTH   = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 6;
    localparam int OUT_TDATA_W  = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam int FLAGS_W      = 9;
    localparam int TWIN_W       = 22;
    // Word 3 bits [30:6] are kept: dates and weekday mask
    localparam int DWIN_W       = 25;
    localparam int DWIN_LSB     = 6;

    // Window kind flags (word 2 bits [30:22])
    localparam int FLAG_TIME    = 8;
    localparam int FLAG_DATE    = 7;
    localparam int FLAG_SEASON  = 6;
    localparam int FLAG_WEEKDAY = 4;

    localparam int CONT_BIT     = 31;
    localparam int VEHICLE_BIT  = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOUR    = 3'd0,
        CFG_MINUTE  = 3'd1,
        CFG_MONTH   = 3'd2,
        CFG_DAY     = 3'd3,
        CFG_WEEKDAY = 3'd4
    } cfg_index_t;

    // Command passed from the front part to the back part
    typedef struct packed {
        logic               judge;
        logic               always_hit;
        logic               last;
        logic [FLAGS_W-1:0] flags;
        logic [TWIN_W-1:0]  twin;
        logic [DWIN_W-1:0]  dwin;
    } cmd_t;

endpackage

// ===== hdl/regulation_time_window_judge_top.sv =====
// ----------------------------------------------------------------------------
// regulation_time_window_judge_top
// Judges a regulation's code list against the configured search time.
// ----------------------------------------------------------------------------
// One code word is taken every cycle, with no gaps between items or lists,
// while the command queue has room. The result of a list is made when the
// command of its last word, written into the queue, is read out of it
// straight into the output register. The command queue of QUEUE_DEPTH
// entries lets the input keep running while the output is stalled, until
// the queue fills with pending commands.
module regulation_time_window_judge_top
#(
    parameter int QUEUE_DEPTH = rtwj_pkg::QUEUE_DEPTH
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [rtwj_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rtwj_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [rtwj_pkg::CODE_WIDTH-1:0]         s_tdata,   // [31:0] code_word
    input  logic                                    s_tlast,   // last_word
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [0] always_regulated, [1] window_in, [2] window_out, [7:3] zero
    output logic [rtwj_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    logic           push_valid, push_ready;
    rtwj_pkg::cmd_t push_cmd;
    logic           pop_valid, pop_ready;
    rtwj_pkg::cmd_t pop_cmd;
    logic [2:0]     result;

    rtwj_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_word    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    rtwj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    rtwj_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready),
        .out_valid  (m_tvalid),
        .out_result (result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{(rtwj_pkg::OUT_TDATA_W - 3){1'b0}}, result};

endmodule

// ===== hdl/rtwj_front.sv =====
// ----------------------------------------------------------------------------
// rtwj_front
// Parses code words into codes and issues judge, always and end commands.
// ----------------------------------------------------------------------------
module rtwj_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [rtwj_pkg::CODE_WIDTH-1:0]  in_word,
    input  logic                             in_last,
    output logic                             in_ready,
    output logic                             push_valid,
    output rtwj_pkg::cmd_t                   push_cmd,
    input  logic                             push_ready
);

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } pos_t;

    pos_t                               pos_reg, pos_next;
    logic                               applies_reg, applies_next;
    logic                               finished_reg, finished_next;
    logic [rtwj_pkg::FLAGS_W-1:0]       flags_reg, flags_next;
    logic [rtwj_pkg::TWIN_W-1:0]        twin_reg, twin_next;
    logic                               take;
    logic                               cont;
    rtwj_pkg::cmd_t                     cmd;

    assign in_ready = push_ready;
    assign take     = in_valid && push_ready;
    // a word marked last ends its code whatever bit 31 says
    assign cont     = !in_last && in_word[rtwj_pkg::CONT_BIT];

    always_comb
    begin
        pos_next      = pos_reg;
        applies_next  = applies_reg;
        finished_next = finished_reg;
        flags_next    = flags_reg;
        twin_next     = twin_reg;
        cmd.judge      = 1'b0;
        cmd.always_hit = 1'b0;
        cmd.last       = in_last;
        cmd.flags      = flags_reg;
        cmd.twin       = twin_reg;
        cmd.dwin       = '0;

        if (!finished_reg)
        begin
            unique case (pos_reg)
                POS_SECOND:
                begin
                    flags_next = in_word[30:22];
                    twin_next  = in_word[rtwj_pkg::TWIN_W-1:0];
                    cmd.flags  = in_word[30:22];
                    cmd.twin   = in_word[rtwj_pkg::TWIN_W-1:0];
                    if (cont)
                    begin
                        pos_next = POS_THIRD;
                    end
                    else
                    begin
                        cmd.judge = applies_reg;
                        pos_next  = POS_FIRST;
                    end
                end
                POS_THIRD:
                begin
                    cmd.judge = applies_reg;
                    cmd.dwin  = in_word[30:rtwj_pkg::DWIN_LSB];
                    pos_next  = POS_FIRST;
                end
                default:
                begin
                    applies_next = in_word[rtwj_pkg::VEHICLE_BIT];
                    flags_next   = '0;
                    twin_next    = '0;
                    if (cont)
                    begin
                        pos_next = POS_SECOND;
                    end
                    else
                    begin
                        pos_next = POS_FIRST;
                        if (in_word[rtwj_pkg::VEHICLE_BIT])
                        begin
                            cmd.always_hit = 1'b1;
                            finished_next  = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (in_last)
        begin
            pos_next      = POS_FIRST;
            applies_next  = 1'b0;
            finished_next = 1'b0;
            flags_next    = '0;
            twin_next     = '0;
        end
    end

    assign push_valid = take && (cmd.judge || cmd.always_hit || cmd.last);
    assign push_cmd   = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_FIRST;
            applies_reg  <= 1'b0;
            finished_reg <= 1'b0;
            flags_reg    <= '0;
            twin_reg     <= '0;
        end
        else if (take)
        begin
            pos_reg      <= pos_next;
            applies_reg  <= applies_next;
            finished_reg <= finished_next;
            flags_reg    <= flags_next;
            twin_reg     <= twin_next;
        end
    end

endmodule

// ===== hdl/rtwj_queue.sv =====
// ----------------------------------------------------------------------------
// rtwj_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module rtwj_queue
#(
    parameter int DEPTH = rtwj_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  rtwj_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output rtwj_pkg::cmd_t pop_cmd,
    input  logic           pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtwj_pkg::cmd_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers wrap at DEPTH, which need not be a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/rtwj_back.sv =====
// ----------------------------------------------------------------------------
// rtwj_back
// Judges codes against the search time, accumulates and emits the result.
// ----------------------------------------------------------------------------
module rtwj_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtwj_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtwj_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pop_valid,
    input  rtwj_pkg::cmd_t                      pop_cmd,
    output logic                                pop_ready,
    output logic                                out_valid,
    output logic [2:0]                          out_result,
    input  logic                                out_ready
);

    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [3:0] month_reg;
    logic [4:0] day_reg;
    logic [2:0] weekday_reg;

    logic [2:0] acc_reg, acc_next;
    logic       out_valid_reg;
    logic [2:0] out_result_reg;
    logic       do_pop;

    // time window
    logic [4:0] sh, eh;
    logic [5:0] sm, em;
    logic [5:0] ehx, h, h24;
    logic       t_in, t_out;
    // date window
    logic [3:0] smo, emo;
    logic [4:0] sd, ed;
    logic [4:0] emox, mo, mo12, smo12;
    logic       d_inside;
    // weekday
    logic [6:0] wmask;
    logic [2:0] widx;
    logic       w_in;
    logic       got_in, got_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg    <= 5'd0;
            minute_reg  <= 6'd0;
            month_reg   <= 4'd1;
            day_reg     <= 5'd1;
            weekday_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtwj_pkg::CFG_HOUR:    hour_reg    <= cfg_data[4:0];
                rtwj_pkg::CFG_MINUTE:  minute_reg  <= cfg_data;
                rtwj_pkg::CFG_MONTH:   month_reg   <= cfg_data[3:0];
                rtwj_pkg::CFG_DAY:     day_reg     <= cfg_data[4:0];
                rtwj_pkg::CFG_WEEKDAY: weekday_reg <= cfg_data[2:0];
                default:               ;
            endcase
        end
    end

    assign sh  = pop_cmd.twin[21:17];
    assign sm  = pop_cmd.twin[16:11];
    assign eh  = pop_cmd.twin[10:6];
    assign em  = pop_cmd.twin[5:0];
    assign h   = {1'b0, hour_reg};
    assign h24 = h + 6'd24;

    always_comb
    begin
        t_in  = 1'b0;
        t_out = 1'b0;
        ehx   = {1'b0, eh};
        if (sh == 5'd0 && eh == 5'd24 && sm == 6'd0 && em == 6'd0)
        begin
            // all day counts as inside
            t_in = 1'b1;
        end
        else
        begin
            // window past midnight: move the end on by a day
            if ((sh == eh && sm > em) || sh > eh)
            begin
                ehx = {1'b0, eh} + 6'd24;
            end
            if (({1'b0, sh} <= h && ehx >= h) || ({1'b0, sh} <= h24 && ehx >= h24))
            begin
                if ({1'b0, sh} == h)
                begin
                    t_in  = (sm <= minute_reg);
                    t_out = !(sm <= minute_reg);
                end
                else if (ehx == h || ehx == h24)
                begin
                    t_in  = (em > minute_reg);
                    t_out = !(em > minute_reg);
                end
                else
                begin
                    t_in = 1'b1;
                end
            end
            else
            begin
                t_out = 1'b1;
            end
        end
    end

    assign smo   = pop_cmd.dwin[24:21];
    assign sd    = pop_cmd.dwin[20:16];
    assign emo   = pop_cmd.dwin[15:12];
    assign ed    = pop_cmd.dwin[11:7];
    assign wmask = pop_cmd.dwin[6:0];
    assign mo    = {1'b0, month_reg};
    assign mo12  = mo + 5'd12;
    assign smo12 = {1'b0, smo} + 5'd12;

    always_comb
    begin
        emox = {1'b0, emo};
        // date window past year end, unless it is a season
        if (!pop_cmd.flags[rtwj_pkg::FLAG_SEASON] && ((smo == emo && sd > ed) || smo > emo))
        begin
            emox = {1'b0, emo} + 5'd12;
        end
        if (({1'b0, smo} <= mo && emox >= mo) || ({1'b0, smo} <= mo12 && emox >= mo12))
        begin
            if ({1'b0, smo} == emox || smo12 == emox)
            begin
                if (sd > ed)
                begin
                    d_inside = (ed >= day_reg) || (sd <= day_reg);
                end
                else
                begin
                    d_inside = !(sd > day_reg || ed < day_reg);
                end
            end
            else if ({1'b0, smo} == mo)
            begin
                d_inside = (sd <= day_reg);
            end
            else if (emox == mo)
            begin
                d_inside = (ed >= day_reg);
            end
            else
            begin
                d_inside = 1'b1;
            end
        end
        else
        begin
            d_inside = 1'b0;
        end
    end

    // mask bit 6 is Sunday
    assign widx = 3'd6 - weekday_reg;
    assign w_in = (weekday_reg <= 3'd6) && ((wmask >> widx) & 7'd1) != 7'd0;

    assign got_out = (pop_cmd.flags[rtwj_pkg::FLAG_TIME] && t_out)
                  || (pop_cmd.flags[rtwj_pkg::FLAG_DATE] && !d_inside)
                  || (pop_cmd.flags[rtwj_pkg::FLAG_WEEKDAY] && !w_in);
    assign got_in  = (pop_cmd.flags[rtwj_pkg::FLAG_TIME] && t_in)
                  || (pop_cmd.flags[rtwj_pkg::FLAG_DATE] && d_inside)
                  || (pop_cmd.flags[rtwj_pkg::FLAG_WEEKDAY] && w_in);

    // accumulator bits: 0 always, 1 in, 2 out
    always_comb
    begin
        acc_next = acc_reg;
        if (pop_cmd.always_hit)
        begin
            acc_next[0] = 1'b1;
        end
        if (pop_cmd.judge)
        begin
            if (got_out)
            begin
                acc_next[2] = 1'b1;
            end
            else if (got_in)
            begin
                acc_next[1] = 1'b1;
            end
        end
    end

    assign pop_ready = !pop_cmd.last || !out_valid_reg || out_ready;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop && pop_cmd.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_pop)
            begin
                if (pop_cmd.last)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_cmd.last)
        begin
            out_result_reg <= acc_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule
